### hw/rtl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

  // Default number of entries the queue holds.
  localparam int unsigned QueueDepthDefault = 16;

  // Width of the reported entry count.
  localparam int unsigned EntryCountW = 5;

  // Operation codes on the mode input.
  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRemove = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/mpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // At most one write and one registered read each cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/max_priority_queue_unsorted.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// command   in         start_i high, busy_o low  mode_i, value_i
// result    out        done_o for one cycle      removed_value_o, empty_error_o,
//                                                full_error_o, entry_count_o,
//                                                is_empty_o
//
// Insert, full insert and empty remove are handled in the idle state; the result shows in the
// next cycle, when a new item may already be accepted.
// A remove of the maximum holds busy_o high while it scans the N stored entries,
// one entry per cycle through the single read port, and then moves each entry above
// the maximum down one slot to close the gap; the result shows in the cycle after.
// Reset clears the count and the control state; the entry memory is not cleared.
// The receiver cannot stall: every result is valid for exactly one cycle.

module max_priority_queue_unsorted
  import mpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    mode_i,
  input  wire logic signed [31:0]      value_i,
  output logic                         done_o,
  output logic signed [31:0]           removed_value_o,
  output logic                         empty_error_o,
  output logic                         full_error_o,
  output logic [EntryCountW-1:0]       entry_count_o,
  output logic                         is_empty_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] OneC = CW'(1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;        // scan: position whose data arrives; shift: write slot
  logic [CW-1:0] best_idx_q, best_idx_d;
  logic signed [31:0] best_q, best_d;

  logic done_q, done_d;
  logic signed [31:0] rem_q, rem_d;
  logic empty_err_q, empty_err_d;
  logic full_err_q, full_err_d;
  logic [EntryCountW-1:0] res_count_q, res_count_d;
  logic res_empty_q, res_empty_d;

  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [CW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          take_new;
  logic [CW-1:0] sel_idx;
  logic signed [31:0] sel_val;

  mpq_ram #(
    .Width(32),
    .Depth(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr[AW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Running maximum: the first entry seeds it, a later one wins only if strictly larger,
  // so the earliest entry keeps a tie.
  assign take_new = (idx_q == '0) || ($signed(ram_rdata) > best_q);
  assign sel_idx  = take_new ? idx_q : best_idx_q;
  assign sel_val  = take_new ? $signed(ram_rdata) : best_q;

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    done_d      = 1'b0;
    rem_d       = rem_q;
    empty_err_d = empty_err_q;
    full_err_d  = full_err_q;
    res_count_d = res_count_q;
    res_empty_d = res_empty_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q;
    ram_wdata   = value_i;
    ram_raddr   = '0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          if (mode_i == ModeInsert) begin
            // Append at the tail, or drop the item when full.
            done_d      = 1'b1;
            rem_d       = '0;
            empty_err_d = 1'b0;
            if (count_q >= DepthC) begin
              full_err_d  = 1'b1;
              res_count_d = EntryCountW'(count_q);
              res_empty_d = (count_q == '0);
            end else begin
              ram_we      = 1'b1;
              full_err_d  = 1'b0;
              count_d     = count_q + OneC;
              res_count_d = EntryCountW'(count_q + OneC);
              res_empty_d = 1'b0;
            end
          end else if (count_q == '0) begin
            done_d      = 1'b1;
            rem_d       = '0;
            empty_err_d = 1'b1;
            full_err_d  = 1'b0;
            res_count_d = '0;
            res_empty_d = 1'b1;
          end else begin
            // Issue the read of the head entry and start the scan.
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = StScan;
          end
        end
      end

      StScan: begin
        best_idx_d = sel_idx;
        best_d     = sel_val;
        if (idx_q + OneC >= count_q) begin
          // Last entry seen: fetch the one after the maximum to close the gap.
          ram_raddr = sel_idx + OneC;
          idx_d     = sel_idx;
          state_d   = StShift;
        end else begin
          ram_raddr = idx_q + OneC;
          idx_d     = idx_q + OneC;
        end
      end

      StShift: begin
        if (idx_q + OneC < count_q) begin
          // Move the fetched entry down one slot, fetch the next.
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = ram_rdata;
          ram_raddr = idx_q + CW'(2);
          idx_d     = idx_q + OneC;
        end else begin
          count_d     = count_q - OneC;
          done_d      = 1'b1;
          rem_d       = best_q;
          empty_err_d = 1'b0;
          full_err_d  = 1'b0;
          res_count_d = EntryCountW'(count_q - OneC);
          res_empty_d = (count_q == OneC);
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      best_idx_q  <= '0;
      best_q      <= '0;
      done_q      <= 1'b0;
      rem_q       <= '0;
      empty_err_q <= 1'b0;
      full_err_q  <= 1'b0;
      res_count_q <= '0;
      res_empty_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      best_idx_q  <= best_idx_d;
      best_q      <= best_d;
      done_q      <= done_d;
      rem_q       <= rem_d;
      empty_err_q <= empty_err_d;
      full_err_q  <= full_err_d;
      res_count_q <= res_count_d;
      res_empty_q <= res_empty_d;
    end
  end

  assign done_o          = done_q;
  assign removed_value_o = rem_q;
  assign empty_error_o   = empty_err_q;
  assign full_error_o    = full_err_q;
  assign entry_count_o   = res_count_q;
  assign is_empty_o      = res_empty_q;

  // The count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  // A full error leaves the queue full.
  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && full_error_o) |-> (count_q == DepthC))
    else $error("full error while not full");

  // An empty error leaves the queue empty.
  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && empty_error_o) |-> (count_q == '0 && is_empty_o))
    else $error("empty error while not empty");

  // Gap closing only writes below the stored count.
  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift && ram_we) |-> (ram_waddr + OneC < count_q))
    else $error("shift write beyond stored entries");

  // A finished remove shrinks the count by one.
  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift && state_d == StIdle) |=> (count_q == $past(count_q) - OneC))
    else $error("remove did not decrement count");

endmodule

`default_nettype wire
